// ----- hw/rtl/ngga_pkg.sv -----
`timescale 1ns / 1ps

package ngga_pkg;

    // Character codes
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_POINT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_SOUTH  = 8'h53;
    localparam logic [7:0] CHAR_WEST   = 8'h57;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_P      = 8'h50;
    localparam logic [7:0] CHAR_A      = 8'h41;

    localparam int PREFIX_LEN = 6;

    // Field numbers, counted from one by commas
    localparam logic [2:0] FIELD_FIRST = 3'd1;
    localparam logic [2:0] FIELD_LAT   = 3'd3;
    localparam logic [2:0] FIELD_NS    = 3'd4;
    localparam logic [2:0] FIELD_LON   = 3'd5;
    localparam logic [2:0] FIELD_EW    = 3'd6;
    localparam logic [2:0] FIELD_LAST  = 3'd7;

    localparam int LANE_LAT = 0;
    localparam int LANE_LON = 1;
    localparam int LANES    = 2;

    // Integer part kept as five BCD digits, saturating at 99999
    localparam int          BCD_W   = 20;
    localparam logic [19:0] BCD_SAT = 20'h99999;

    // Conversion datapath widths
    localparam int OUT_W = 31;   // signed microdegrees
    localparam int MAG_W = 30;   // magnitude, below 1.001e9
    localparam int DEG_W = 10;   // whole degrees, up to 999
    localparam int M2_W  = 27;   // minutes scaled by 1e6, below 1e8
    localparam int QUO_W = 21;   // scaled minutes / 60, below 1666667

    localparam int UDEG_PER_DEG = 1_000_000;

    // x / 15 for x below 2**25: (x * ceil(2**29 / 15)) >> 29
    localparam int          X_W         = M2_W - 2;
    localparam int          RECIP_W     = 26;
    localparam int          RECIP_SHIFT = 29;
    localparam logic [25:0] RECIP_15    = 26'd35791395;
    localparam int          PROD_W      = X_W + RECIP_W;

    localparam logic signed [OUT_W-1:0] UDEG_MAX = 31'sd1000999999;

    function automatic int pow10(input int n);
        int r;
        r = 1;
        for (int i = 0; i < 6; i++)
        begin
            if (i < n)
            begin
                r = r * 10;
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CHAR_DOLLAR;
            3'd1:    c = CHAR_G;
            3'd2:    c = CHAR_P;
            3'd3:    c = CHAR_G;
            3'd4:    c = CHAR_G;
            default: c = CHAR_A;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/ngga_byte_if.sv -----
`timescale 1ns / 1ps

interface ngga_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- hw/rtl/ngga_pos_if.sv -----
`timescale 1ns / 1ps

interface ngga_pos_if
    import ngga_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] latitude_udeg;
    logic signed [OUT_W-1:0] longitude_udeg;

    modport source (output valid, output latitude_udeg, output longitude_udeg, input ready);
    modport sink   (input valid, input latitude_udeg, input longitude_udeg, output ready);
endinterface

// ----- hw/rtl/nmea_gga_position_parser.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Payload                                   Transaction
// rx       in   rx_byte [7:0]                             one stream character
// pos      out  latitude_udeg, longitude_udeg [30:0] s    one position per GGA line
//
// One byte is taken every cycle while rx.ready is high. The parse state updates in
// the cycle the byte is taken; a line feed that closes a GGA line enters a four-register
// conversion pipeline (digit capture, scaled minutes, reciprocal multiply for /60,
// sum and sign into the output register), and pos.valid rises when the result
// is loaded into the output register.
// rst_n clears the line state and all pipeline valids at once.
// A stalled output holds; empty pipeline slots still fill, and rx.ready drops
// only when every slot holds a result.

module nmea_gga_position_parser
    import ngga_pkg::*;
#(
    parameter int LINE_LIMIT  = 128,
    parameter int FIELD_CHARS = 14,
    parameter int FRAC_DIGITS = 5
)(
    input logic        clk,
    input logic        rst_n,
    ngga_byte_if.sink  rx,
    ngga_pos_if.source pos
);

    localparam int POS_W      = $clog2(LINE_LIMIT);
    localparam int FCC_W      = $clog2(FIELD_CHARS + 1);
    localparam int FRAC_W     = $clog2(10 ** FRAC_DIGITS);
    localparam int FCNT_W     = $clog2(FRAC_DIGITS + 1);
    localparam int FRAC_SCALE = 10 ** (6 - FRAC_DIGITS);

    // Line parse state
    logic [POS_W-1:0]  line_pos_reg, line_pos_next;
    logic              prefix_reg, prefix_next;
    logic [2:0]        field_reg, field_next;
    logic [FCC_W-1:0]  fcc_reg, fcc_next;
    logic [BCD_W-1:0]  bcd_reg [LANES];
    logic [BCD_W-1:0]  bcd_next [LANES];
    logic [FRAC_W-1:0] frac_reg [LANES];
    logic [FRAC_W-1:0] frac_next [LANES];
    logic [FCNT_W-1:0] fcnt_reg [LANES];
    logic [FCNT_W-1:0] fcnt_next [LANES];
    logic              point_reg [LANES];
    logic              point_next [LANES];
    logic              ended_reg [LANES];
    logic              ended_next [LANES];
    logic [LANES-1:0]  sign_reg, sign_next;

    // Digit update candidates, one per lane
    logic [BCD_W-1:0]  bcd_take [LANES];
    logic [FRAC_W-1:0] frac_take [LANES];
    logic [FCNT_W-1:0] fcnt_take [LANES];
    logic              point_take [LANES];
    logic              ended_take [LANES];

    logic       accept;
    logic       emit;
    logic       is_digit;
    logic [3:0] digit;

    // Pipeline
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic out_valid_reg, out_valid_next;
    logic s1_free, s2_free, s3_free, out_free;

    logic [BCD_W-1:0]  s1_bcd_reg [LANES];
    logic [FRAC_W-1:0] s1_frac_reg [LANES];
    logic [LANES-1:0]  s1_sign_reg;

    logic [DEG_W-1:0]  s2_deg_reg [LANES];
    logic [M2_W-1:0]   s2_m2_reg [LANES];
    logic [LANES-1:0]  s2_sign_reg;
    logic [DEG_W-1:0]  s2_deg_next [LANES];
    logic [M2_W-1:0]   s2_m2_next [LANES];

    logic [MAG_W-1:0]  s3_degu_reg [LANES];
    logic [QUO_W-1:0]  s3_quo_reg [LANES];
    logic [LANES-1:0]  s3_sign_reg;
    logic [MAG_W-1:0]  s3_degu_next [LANES];
    logic [QUO_W-1:0]  s3_quo_next [LANES];
    logic [PROD_W-1:0] s2_prod [LANES];

    logic [MAG_W-1:0]        s3_mag [LANES];
    logic signed [OUT_W-1:0] out_udeg_reg [LANES];
    logic signed [OUT_W-1:0] out_udeg_next [LANES];

    assign accept = rx.valid && rx.ready;

    assign is_digit = (rx.rx_byte >= CHAR_ZERO) && (rx.rx_byte <= CHAR_NINE);
    assign digit    = 4'(rx.rx_byte - CHAR_ZERO);

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            bcd_take[l]   = bcd_reg[l];
            frac_take[l]  = frac_reg[l];
            fcnt_take[l]  = fcnt_reg[l];
            point_take[l] = point_reg[l];
            ended_take[l] = ended_reg[l];
            if (!ended_reg[l])
            begin
                if (is_digit)
                begin
                    if (!point_reg[l])
                    begin
                        // a fifth digit already present means the next one overflows
                        if (bcd_reg[l][BCD_W-1 -: 4] != 4'd0)
                        begin
                            bcd_take[l] = BCD_SAT;
                        end
                        else
                        begin
                            bcd_take[l] = {bcd_reg[l][BCD_W-5:0], digit};
                        end
                    end
                    else if (fcnt_reg[l] < FCNT_W'(FRAC_DIGITS))
                    begin
                        // keep the fraction left-aligned to FRAC_DIGITS places
                        frac_take[l] = frac_reg[l] + FRAC_W'(digit)
                            * FRAC_W'(pow10(FRAC_DIGITS - 1 - int'(fcnt_reg[l])));
                        fcnt_take[l] = fcnt_reg[l] + FCNT_W'(1);
                    end
                end
                else if (rx.rx_byte == CHAR_POINT && !point_reg[l])
                begin
                    point_take[l] = 1'b1;
                end
                else
                begin
                    ended_take[l] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        line_pos_next = line_pos_reg;
        prefix_next   = prefix_reg;
        field_next    = field_reg;
        fcc_next      = fcc_reg;
        sign_next     = sign_reg;
        for (int l = 0; l < LANES; l++)
        begin
            bcd_next[l]   = bcd_reg[l];
            frac_next[l]  = frac_reg[l];
            fcnt_next[l]  = fcnt_reg[l];
            point_next[l] = point_reg[l];
            ended_next[l] = ended_reg[l];
        end
        emit = 1'b0;

        if (accept)
        begin
            if (rx.rx_byte == CHAR_LF)
            begin
                emit          = prefix_reg && (line_pos_reg >= POS_W'(PREFIX_LEN));
                line_pos_next = '0;
                prefix_next   = 1'b1;
                field_next    = FIELD_FIRST;
                fcc_next      = '0;
                sign_next     = '0;
                for (int l = 0; l < LANES; l++)
                begin
                    bcd_next[l]   = '0;
                    frac_next[l]  = '0;
                    fcnt_next[l]  = '0;
                    point_next[l] = 1'b0;
                    ended_next[l] = 1'b0;
                end
            end
            else if (rx.rx_byte != CHAR_CR && line_pos_reg < POS_W'(LINE_LIMIT - 1))
            begin
                if (line_pos_reg < POS_W'(PREFIX_LEN)
                    && rx.rx_byte != prefix_char(line_pos_reg[2:0]))
                begin
                    prefix_next = 1'b0;
                end
                line_pos_next = line_pos_reg + POS_W'(1);

                if (rx.rx_byte == CHAR_COMMA)
                begin
                    if (field_reg != FIELD_LAST)
                    begin
                        field_next = field_reg + 3'd1;
                    end
                    fcc_next = '0;
                end
                else if (fcc_reg < FCC_W'(FIELD_CHARS))
                begin
                    case (field_reg)
                        FIELD_LAT:
                        begin
                            bcd_next[LANE_LAT]   = bcd_take[LANE_LAT];
                            frac_next[LANE_LAT]  = frac_take[LANE_LAT];
                            fcnt_next[LANE_LAT]  = fcnt_take[LANE_LAT];
                            point_next[LANE_LAT] = point_take[LANE_LAT];
                            ended_next[LANE_LAT] = ended_take[LANE_LAT];
                        end
                        FIELD_NS:
                        begin
                            if (fcc_reg == '0 && rx.rx_byte == CHAR_SOUTH)
                            begin
                                sign_next[LANE_LAT] = 1'b1;
                            end
                        end
                        FIELD_LON:
                        begin
                            bcd_next[LANE_LON]   = bcd_take[LANE_LON];
                            frac_next[LANE_LON]  = frac_take[LANE_LON];
                            fcnt_next[LANE_LON]  = fcnt_take[LANE_LON];
                            point_next[LANE_LON] = point_take[LANE_LON];
                            ended_next[LANE_LON] = ended_take[LANE_LON];
                        end
                        FIELD_EW:
                        begin
                            if (fcc_reg == '0 && rx.rx_byte == CHAR_WEST)
                            begin
                                sign_next[LANE_LON] = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    fcc_next = fcc_reg + FCC_W'(1);
                end
            end
        end
    end

    // Ready chain: a slot takes new data when empty or when it moves on
    assign out_free = !out_valid_reg || pos.ready;
    assign s3_free  = !s3_valid_reg || out_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign rx.ready = s1_free;

    assign s1_valid_next  = s1_free  ? emit         : s1_valid_reg;
    assign s2_valid_next  = s2_free  ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next  = s3_free  ? s2_valid_reg : s3_valid_reg;
    assign out_valid_next = out_free ? s3_valid_reg : out_valid_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            // degrees from the top three BCD digits
            s2_deg_next[l] = DEG_W'(s1_bcd_reg[l][19:16]) * DEG_W'(100)
                           + DEG_W'(s1_bcd_reg[l][15:12]) * DEG_W'(10)
                           + DEG_W'(s1_bcd_reg[l][11:8]);
            // whole and fractional minutes, scaled by 1e6
            s2_m2_next[l] = M2_W'(s1_bcd_reg[l][7:4]) * M2_W'(10 * UDEG_PER_DEG)
                          + M2_W'(s1_bcd_reg[l][3:0]) * M2_W'(UDEG_PER_DEG)
                          + M2_W'(s1_frac_reg[l]) * M2_W'(FRAC_SCALE);

            // divide by 60: drop two bits, then multiply by the reciprocal of 15
            s2_prod[l]        = PROD_W'(s2_m2_reg[l][M2_W-1:2]) * PROD_W'(RECIP_15);
            s3_quo_next[l]    = s2_prod[l][RECIP_SHIFT +: QUO_W];
            s3_degu_next[l]   = MAG_W'(s2_deg_reg[l]) * MAG_W'(UDEG_PER_DEG);

            s3_mag[l] = s3_degu_reg[l] + MAG_W'(s3_quo_reg[l]);
            out_udeg_next[l] = s3_sign_reg[l] ? -$signed(OUT_W'(s3_mag[l]))
                                              : $signed(OUT_W'(s3_mag[l]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_pos_reg  <= '0;
            prefix_reg    <= 1'b1;
            field_reg     <= FIELD_FIRST;
            fcc_reg       <= '0;
            sign_reg      <= '0;
            for (int l = 0; l < LANES; l++)
            begin
                bcd_reg[l]   <= '0;
                frac_reg[l]  <= '0;
                fcnt_reg[l]  <= '0;
                point_reg[l] <= 1'b0;
                ended_reg[l] <= 1'b0;
            end
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            line_pos_reg  <= line_pos_next;
            prefix_reg    <= prefix_next;
            field_reg     <= field_next;
            fcc_reg       <= fcc_next;
            sign_reg      <= sign_next;
            for (int l = 0; l < LANES; l++)
            begin
                bcd_reg[l]   <= bcd_next[l];
                frac_reg[l]  <= frac_next[l];
                fcnt_reg[l]  <= fcnt_next[l];
                point_reg[l] <= point_next[l];
                ended_reg[l] <= ended_next[l];
            end
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Pipeline payload, loaded as each slot advances
    always_ff @(posedge clk)
    begin
        if (s1_free && emit)
        begin
            s1_bcd_reg  <= bcd_reg;
            s1_frac_reg <= frac_reg;
            s1_sign_reg <= sign_reg;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_deg_reg  <= s2_deg_next;
            s2_m2_reg   <= s2_m2_next;
            s2_sign_reg <= s1_sign_reg;
        end
        if (s3_free && s2_valid_reg)
        begin
            s3_degu_reg <= s3_degu_next;
            s3_quo_reg  <= s3_quo_next;
            s3_sign_reg <= s2_sign_reg;
        end
        if (out_free && s3_valid_reg)
        begin
            out_udeg_reg <= out_udeg_next;
        end
    end

    assign pos.valid          = out_valid_reg;
    assign pos.latitude_udeg  = out_udeg_reg[LANE_LAT];
    assign pos.longitude_udeg = out_udeg_reg[LANE_LON];

endmodule

// ----- hw/rtl/ngga_checker.sv -----
`timescale 1ns / 1ps

module ngga_checker
    import ngga_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [OUT_W-1:0] latitude_udeg,
    input logic signed [OUT_W-1:0] longitude_udeg
);

    // A stalled result holds its position
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(latitude_udeg)
                                    && $stable(longitude_udeg))
        else $error("position changed while stalled");

    // With no result waiting the pipeline has room for a byte
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // A byte waits only behind a stalled result
    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while output moves");

    // Positions stay within the range of a dddmm.mmmm field
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> latitude_udeg <= UDEG_MAX && latitude_udeg >= -UDEG_MAX
                      && longitude_udeg <= UDEG_MAX && longitude_udeg >= -UDEG_MAX)
        else $error("position out of range");

    // No result comes out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

endmodule

bind nmea_gga_position_parser ngga_checker u_ngga_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (rx.valid),
    .in_ready       (rx.ready),
    .out_valid      (pos.valid),
    .out_ready      (pos.ready),
    .latitude_udeg  (pos.latitude_udeg),
    .longitude_udeg (pos.longitude_udeg)
);
